/* design/fpv_pkg.sv */
// Shared types, constants and helpers for the FAT path validator.
package fpv_pkg;

    // Widths of the fields and registers
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int CODE_W  = 21;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COMP = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] MAX_PATH_RESET = 16'd1024;
    localparam logic [CFG_W-1:0] MAX_COMP_RESET = 16'd255;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

    // Code point limits
    localparam logic [CODE_W-1:0] CODE_MAX  = 21'h10ffff;
    localparam logic [CODE_W-1:0] SURR_LO   = 21'h00d800;
    localparam logic [CODE_W-1:0] SURR_HI   = 21'h00dfff;
    localparam logic [CODE_W-1:0] MIN_THREE = 21'h000800;
    localparam logic [CODE_W-1:0] MIN_FOUR  = 21'h010000;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

    // Sequence lengths counted in continuation bytes
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef enum logic [1:0] {
        REASON_OK     = 2'd0,
        REASON_STRUCT = 2'd1,
        REASON_UTF8   = 2'd2,
        REASON_FAT    = 2'd3
    } reason_t;

    // Control from the top level to the decoder
    typedef struct packed {
        logic feed;   // a path byte is taken this cycle
        logic clear;  // the path ends this cycle
        logic last;   // the byte taken is the final one
    } utf8_ctrl_t;

    // Status from the decoder
    typedef struct packed {
        logic fail;   // encoding fault so far, this byte and truncation included
    } utf8_stat_t;

    // Characters that FAT forbids in a name
    function automatic logic fat_bad_char(input logic [BYTE_W-1:0] b);
        return (b < CTRL_LIMIT) || (b == 8'h3c) || (b == 8'h3e) || (b == 8'h3a) ||
               (b == 8'h22) || (b == 8'h7c) || (b == 8'h3f) || (b == 8'h2a);
    endfunction

endpackage

/* design/fpv_utf8.sv */
// UTF-8 sequence decoder with sticky fault flag for one path.
module fpv_utf8
    import fpv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  utf8_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] in_byte,
    output utf8_stat_t        stat
);

    logic [1:0]        left_reg, left_next;
    logic [1:0]        len_reg, len_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              failed_reg;
    logic              bad;

    // Decode one byte against the running sequence
    always_comb begin
        left_next = left_reg;
        len_next  = len_reg;
        code_next = code_reg;
        bad       = 1'b0;
        if (left_reg == 2'd0) begin
            priority if (!in_byte[7]) begin
                bad = 1'b0;
            end else if (in_byte[7:5] == 3'b110) begin
                code_next = {16'd0, in_byte[4:0]};
                if (in_byte[4:1] == 4'd0) begin
                    bad = 1'b1;
                end else begin
                    len_next  = SEQ_TWO;
                    left_next = SEQ_TWO;
                end
            end else if (in_byte[7:4] == 4'b1110) begin
                code_next = {17'd0, in_byte[3:0]};
                len_next  = SEQ_THREE;
                left_next = SEQ_THREE;
            end else if (in_byte[7:3] == 5'b11110) begin
                code_next = {18'd0, in_byte[2:0]};
                len_next  = SEQ_FOUR;
                left_next = SEQ_FOUR;
            end else begin
                bad = 1'b1;
            end
        end else begin
            if (in_byte[7:6] != 2'b10) begin
                bad       = 1'b1;
                left_next = 2'd0;
            end else begin
                code_next = {code_reg[CODE_W-7:0], in_byte[5:0]};
                left_next = left_reg - 2'd1;
                if (left_next == 2'd0) begin
                    if ((len_reg == SEQ_THREE && code_next < MIN_THREE) ||
                        (len_reg == SEQ_FOUR && code_next < MIN_FOUR) ||
                        (code_next > CODE_MAX) ||
                        (code_next >= SURR_LO && code_next <= SURR_HI)) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign stat.fail = failed_reg | bad | (ctrl.last && left_next != 2'd0);

    // Advance on each byte, return to idle at the end of a path
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            left_reg   <= 2'd0;
            len_reg    <= 2'd0;
            code_reg   <= '0;
            failed_reg <= 1'b0;
        end else if (ctrl.feed) begin
            left_reg   <= left_next;
            len_reg    <= len_next;
            code_reg   <= code_next;
            failed_reg <= failed_reg | bad;
        end
    end

endmodule

/* design/fat_path_validator.sv */
// Top level of the streaming FAT path validator.
//
//  channel | direction | beat contents
//  s_      | in        | tdata[7:0] path_byte, tlast last_byte, tuser empty_path
//  m_      | out       | tdata[0] path_ok, tdata[2:1] fail_reason, tdata[7:3] zero
//  cfg_    | in        | cfg_addr register index, cfg_wdata value, cfg_we strobe
//
// One path byte is taken every cycle while s_tready is high; the verdict is formed
// from the running state and the final beat and appears in the result register in
// the cycle after that beat. s_tready is low only while a verdict is held in the
// result register and m_tready is low. Synchronous active-low reset clears all path
// state and the result valid flag and restores the register defaults (1024 and 255).
module fat_path_validator
    import fpv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] path_byte
    input  logic                 s_tlast,
    input  logic                 s_tuser,   // [0] empty_path
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] path_ok, [2:1] fail_reason, [7:3] zero
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0]   max_path_reg, max_comp_reg;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] comp_len_reg, comp_len_next, comp_inc;
    logic               all_dots_reg, all_dots_next;
    logic [BYTE_W-1:0]  prev_char_reg;
    logic               at_start_reg;
    logic               struct_fail_reg, struct_fail_next;
    logic               fat_fail_reg, fat_fail_next;
    logic               m_valid_reg;
    logic               path_ok_reg;
    reason_t            reason_reg, reason_next;

    logic               s_acc, step, final_beat, is_slash;
    logic [COUNT_W-1:0] close_len;
    logic               close_dots, close_en;
    logic [BYTE_W-1:0]  close_tail;
    utf8_ctrl_t         u_ctrl;
    utf8_stat_t         u_stat;

    assign s_tready   = !m_valid_reg || m_tready;
    assign s_acc      = s_tvalid && s_tready;
    assign step       = s_acc && !s_tuser;
    assign final_beat = s_acc && (s_tuser || s_tlast);
    assign is_slash   = (s_tdata == CH_SLASH);

    assign u_ctrl.feed  = step;
    assign u_ctrl.clear = final_beat;
    assign u_ctrl.last  = s_tlast;

    fpv_utf8 u_utf8 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (u_ctrl),
        .in_byte (s_tdata),
        .stat    (u_stat)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_path_reg <= MAX_PATH_RESET;
            max_comp_reg <= MAX_COMP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_PATH: max_path_reg <= cfg_wdata;
                REG_MAX_COMP: max_comp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturating counters
    assign byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                           : byte_count_reg + 16'd1;
    assign comp_inc = (comp_len_reg == COUNT_MAX) ? comp_len_reg : comp_len_reg + 16'd1;

    // Pick the component that closes on this byte, if any
    always_comb begin
        if (is_slash) begin
            close_len  = comp_len_reg;
            close_dots = all_dots_reg;
            close_tail = prev_char_reg;
            close_en   = (comp_len_reg != 16'd0);
        end else begin
            close_len  = comp_inc;
            close_dots = all_dots_reg && (s_tdata == CH_DOT);
            close_tail = s_tdata;
            close_en   = s_tlast;
        end
    end

    // Structure and FAT checks for one byte
    always_comb begin
        struct_fail_next = struct_fail_reg || (byte_count_next >= max_path_reg) ||
                           (at_start_reg && (is_slash || s_tdata == CH_BSLASH));
        fat_fail_next    = fat_fail_reg;
        if (is_slash) begin
            comp_len_next = '0;
            all_dots_next = 1'b1;
            if (comp_len_reg == 16'd0 || s_tlast) begin
                struct_fail_next = 1'b1;
            end
        end else begin
            comp_len_next = comp_inc;
            all_dots_next = close_dots;
            if (s_tdata == CH_BSLASH) begin
                struct_fail_next = 1'b1;
            end
            if (fat_bad_char(s_tdata)) begin
                fat_fail_next = 1'b1;
            end
        end
        if (close_en) begin
            if (close_dots && close_len <= 16'd2) begin
                struct_fail_next = 1'b1;
            end
            if (close_len > max_comp_reg || close_tail == CH_SPACE ||
                close_tail == CH_DOT) begin
                fat_fail_next = 1'b1;
            end
        end
    end

    // Verdict, structure first
    always_comb begin
        priority if (s_tuser || struct_fail_next) begin
            reason_next = REASON_STRUCT;
        end else if (u_stat.fail) begin
            reason_next = REASON_UTF8;
        end else if (fat_fail_next) begin
            reason_next = REASON_FAT;
        end else begin
            reason_next = REASON_OK;
        end
    end

    // Path state: advance per byte, drop at the end of a path
    always_ff @(posedge aclk) begin
        if (!aresetn || final_beat) begin
            byte_count_reg  <= '0;
            comp_len_reg    <= '0;
            all_dots_reg    <= 1'b1;
            prev_char_reg   <= '0;
            at_start_reg    <= 1'b1;
            struct_fail_reg <= 1'b0;
            fat_fail_reg    <= 1'b0;
        end else if (step) begin
            byte_count_reg  <= byte_count_next;
            comp_len_reg    <= comp_len_next;
            all_dots_reg    <= all_dots_next;
            prev_char_reg   <= s_tdata;
            at_start_reg    <= 1'b0;
            struct_fail_reg <= struct_fail_next;
            fat_fail_reg    <= fat_fail_next;
        end
    end

    // Result register: load on a final beat, hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= final_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (final_beat) begin
            reason_reg  <= reason_next;
            path_ok_reg <= (reason_next == REASON_OK);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, reason_reg, path_ok_reg};

    // The flag and the code of a verdict agree
    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (path_ok_reg == (reason_reg == REASON_OK)))
        else $error("path_ok disagrees with fail_reason");

    // A final beat always yields a verdict in the next cycle
    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        final_beat |=> m_valid_reg)
        else $error("final beat produced no verdict");

    // Path state is cleared after a final beat
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        final_beat |=> (byte_count_reg == 16'd0 && comp_len_reg == 16'd0 &&
                        at_start_reg && !struct_fail_reg && !fat_fail_reg))
        else $error("path state not cleared after verdict");

    // An empty-path beat always reports unsafe structure
    a_empty_unsafe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (reason_reg == REASON_STRUCT && !path_ok_reg))
        else $error("empty path not reported as unsafe");

endmodule
